### hw/rtl/cvc_pkg.sv
// Shared constants and types of the convex volume cull test.
package cvc_pkg;

  // Default sizes of the datapath.
  localparam int MAX_PLANES_DEF  = 6;
  localparam int COORD_BITS_DEF  = 24;
  localparam int NORMAL_BITS_DEF = 12;

  // Configuration register map: planes take indexes 0 to PLANE_REGS-1.
  localparam int PLANE_REGS = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int ACTIVE_W   = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd6;

  // A plane with a zero normal and w of 256, which passes everything.
  localparam int PLANE_RESET  = 256;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd6;

  // Primitive kinds; the unused code is tested like a point.
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_POINT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPHERE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOX    = 2'd2;

  // Control that travels with each request from one cell to the next.
  typedef struct packed {
    logic valid;   // the stage holds a request
    logic in_vol;  // no plane tested so far rejects it
    logic chk;     // the attached products belong to an active plane
  } ctrl_t;

endpackage

### hw/rtl/cvc_cfg.sv
// Configuration registers: plane equations and the active plane count.
module cvc_cfg #(
  parameter int COORD_BITS  = cvc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_BITS = cvc_pkg::NORMAL_BITS_DEF,
  parameter int NCELL       = cvc_pkg::PLANE_REGS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cvc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [3*NORMAL_BITS+COORD_BITS-1:0] cfg_data,
  output logic [3*NORMAL_BITS+COORD_BITS-1:0] plane_o [cvc_pkg::PLANE_REGS],
  output logic [NCELL-1:0]                   active_o
);

  localparam int PW = 3 * NORMAL_BITS + COORD_BITS;

  logic [PW-1:0]                plane_r [cvc_pkg::PLANE_REGS];
  logic [cvc_pkg::ACTIVE_W-1:0] active_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cvc_pkg::PLANE_REGS; i++) begin
        plane_r[i] <= PW'(cvc_pkg::PLANE_RESET);
      end
      active_r <= cvc_pkg::ACTIVE_RESET;
    end else if (cfg_valid) begin
      for (int i = 0; i < cvc_pkg::PLANE_REGS; i++) begin
        if (cfg_index == cvc_pkg::CFG_IDX_W'(i)) begin
          plane_r[i] <= cfg_data;
        end
      end
      if (cfg_index == cvc_pkg::REG_ACTIVE) begin
        active_r <= cfg_data[cvc_pkg::ACTIVE_W-1:0];
      end
    end
  end

  assign plane_o = plane_r;

  // A count above the number of cells simply enables all of them.
  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      active_o[i] = ({1'b0, active_r} > (cvc_pkg::ACTIVE_W + 1)'(i));
    end
  end

endmodule

### hw/rtl/cvc_cell.sv
// One cell of the plane chain: finishes the previous plane, starts its own.
module cvc_cell #(
  parameter int COORD_BITS  = cvc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_BITS = cvc_pkg::NORMAL_BITS_DEF,
  localparam int PW    = 3 * NORMAL_BITS + COORD_BITS,
  localparam int EW    = COORD_BITS - 1,
  localparam int PAY_W = cvc_pkg::KIND_W + 3 * COORD_BITS + 4 * EW,
  localparam int AW    = COORD_BITS + 1,
  localparam int PRW   = NORMAL_BITS + AW,
  localparam int TW    = COORD_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [PW-1:0]          plane_i,
  input  logic                   active_i,
  input  cvc_pkg::ctrl_t         up_ctrl_i,
  input  logic [PAY_W-1:0]       up_pay_i,
  input  logic [3*PRW-1:0]       up_prod_i,
  input  logic signed [TW-1:0]   up_thr_i,
  output logic                   up_ready_o,
  output cvc_pkg::ctrl_t         dn_ctrl_o,
  output logic [PAY_W-1:0]       dn_pay_o,
  output logic [3*PRW-1:0]       dn_prod_o,
  output logic signed [TW-1:0]   dn_thr_o,
  input  logic                   dn_ready_i
);

  localparam int SW   = PRW + 2;
  localparam int FRAC = NORMAL_BITS - 2;

  cvc_pkg::ctrl_t ctrl_r, ctrl_nxt;
  logic [PAY_W-1:0]     pay_r;
  logic [3*PRW-1:0]     prod_r, prod_nxt;
  logic signed [TW-1:0] thr_r, thr_nxt;

  logic [cvc_pkg::KIND_W-1:0]  kind;
  logic [COORD_BITS-1:0]       coord [3];
  logic [EW-1:0]               ext [3];
  logic [EW-1:0]               rad;
  logic signed [NORMAL_BITS-1:0] nrm [3];
  logic signed [AW-1:0]        adj [3];
  logic signed [TW-1:0]        radsel;
  logic signed [SW-1:0]        sdist, thr_sh;
  logic                        reject;

  // Payload layout: kind, center x/y/z, radius, extent x/y/z from bit 0 up.
  always_comb begin
    kind = up_pay_i[cvc_pkg::KIND_W-1:0];
    for (int a = 0; a < 3; a++) begin
      coord[a] = up_pay_i[cvc_pkg::KIND_W + a*COORD_BITS +: COORD_BITS];
      ext[a]   = up_pay_i[cvc_pkg::KIND_W + 3*COORD_BITS + (a+1)*EW +: EW];
      nrm[a]   = $signed(plane_i[PW-1-a*NORMAL_BITS -: NORMAL_BITS]);
    end
    rad = up_pay_i[cvc_pkg::KIND_W + 3*COORD_BITS +: EW];
  end

  // For a box, the extent is folded into the coordinate on the side that
  // faces the plane, so one product per axis covers the corner distance.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      adj[a] = $signed({coord[a][COORD_BITS-1], coord[a]});
      if (kind == cvc_pkg::KIND_BOX) begin
        if (nrm[a][NORMAL_BITS-1]) begin
          adj[a] = $signed({coord[a][COORD_BITS-1], coord[a]}) + $signed({2'b00, ext[a]});
        end else begin
          adj[a] = $signed({coord[a][COORD_BITS-1], coord[a]}) - $signed({2'b00, ext[a]});
        end
      end
    end
    for (int a = 0; a < 3; a++) begin
      prod_nxt[a*PRW +: PRW] = PRW'(nrm[a] * adj[a]);
    end
    radsel  = (kind == cvc_pkg::KIND_SPHERE) ? $signed({2'b00, rad}) : '0;
    thr_nxt = $signed({plane_i[COORD_BITS-1], plane_i[COORD_BITS-1:0]}) + radsel;
  end

  // Compare for the plane of the previous cell.
  always_comb begin
    sdist = SW'($signed(up_prod_i[0 +: PRW])) + SW'($signed(up_prod_i[PRW +: PRW]))
          + SW'($signed(up_prod_i[2*PRW +: PRW]));
    thr_sh = SW'(up_thr_i) <<< FRAC;
    reject = up_ctrl_i.chk && (sdist > thr_sh);
    ctrl_nxt.valid  = up_ctrl_i.valid;
    ctrl_nxt.in_vol = up_ctrl_i.in_vol && !reject;
    ctrl_nxt.chk    = active_i;
  end

  assign up_ready_o = !ctrl_r.valid || dn_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (up_ready_o) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready_o && up_ctrl_i.valid) begin
      pay_r  <= up_pay_i;
      prod_r <= prod_nxt;
      thr_r  <= thr_nxt;
    end
  end

  assign dn_ctrl_o = ctrl_r;
  assign dn_pay_o  = pay_r;
  assign dn_prod_o = prod_r;
  assign dn_thr_o  = thr_r;

endmodule

### hw/rtl/cvc_tail.sv
// End of the chain: compare for the last plane and the output register.
module cvc_tail #(
  parameter int COORD_BITS  = cvc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_BITS = cvc_pkg::NORMAL_BITS_DEF,
  localparam int PRW = NORMAL_BITS + COORD_BITS + 1,
  localparam int TW  = COORD_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cvc_pkg::ctrl_t       up_ctrl_i,
  input  logic [3*PRW-1:0]     up_prod_i,
  input  logic signed [TW-1:0] up_thr_i,
  output logic                 up_ready_o,
  output logic                 out_valid_o,
  output logic                 out_inside_o,
  input  logic                 out_ready_i
);

  localparam int SW   = PRW + 2;
  localparam int FRAC = NORMAL_BITS - 2;

  logic                 valid_r, inside_r;
  logic signed [SW-1:0] sdist, thr_sh;
  logic                 inside_nxt;

  always_comb begin
    sdist = SW'($signed(up_prod_i[0 +: PRW])) + SW'($signed(up_prod_i[PRW +: PRW]))
          + SW'($signed(up_prod_i[2*PRW +: PRW]));
    thr_sh     = SW'(up_thr_i) <<< FRAC;
    inside_nxt = up_ctrl_i.in_vol && !(up_ctrl_i.chk && (sdist > thr_sh));
  end

  assign up_ready_o = !valid_r || out_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready_o) begin
      valid_r <= up_ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready_o && up_ctrl_i.valid) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_valid_o  = valid_r;
  assign out_inside_o = inside_r;

endmodule

### hw/rtl/convex_volume_cull_test.sv
// Top level of the convex volume cull test: a chain of one cell per plane.
//
//  Channel  Direction  Handshake            Payload
//  in_      slave      in_tvalid/in_tready  tuser: req_type; tdata: center, radius, extents
//  out_     master     out_tvalid/out_tready tdata: inside_res in bit 0
//  cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data (one register write)
//
// A new request can enter in every cycle while in_tready is high. Each
// request walks through one cell per plane and then the output register.
// Every stage holds its own valid bit and only stalls when it is full and
// the stage after it is full and stalled, so empty slots are filled even
// while a result waits at the output. A synchronous reset empties the
// chain and restores the always-pass planes with six active.
module convex_volume_cull_test #(
  parameter int MAX_PLANES  = cvc_pkg::MAX_PLANES_DEF,
  parameter int COORD_BITS  = cvc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_BITS = cvc_pkg::NORMAL_BITS_DEF,
  localparam int EW       = COORD_BITS - 1,
  localparam int FIELDS_W = 3 * COORD_BITS + 4 * EW,
  localparam int DATA_W   = ((FIELDS_W + 7) / 8) * 8,
  localparam int PW       = 3 * NORMAL_BITS + COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // From bit 0 up: center_x, center_y, center_z, radius, extent_x,
  // extent_y, extent_z, then zero fill.
  input  logic [DATA_W-1:0]             in_tdata,
  // req_type.
  input  logic [cvc_pkg::KIND_W-1:0]    in_tuser,
  // Result channel.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Bit 0: inside_res; the other bits are zero.
  output logic [7:0]                    out_tdata,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [PW-1:0]                 cfg_data
);

  localparam int NCELL = (MAX_PLANES < cvc_pkg::PLANE_REGS) ? MAX_PLANES
                                                            : cvc_pkg::PLANE_REGS;
  localparam int PAY_W = cvc_pkg::KIND_W + FIELDS_W;
  localparam int PRW   = NORMAL_BITS + COORD_BITS + 1;
  localparam int TW    = COORD_BITS + 1;

  logic [PW-1:0]    plane [cvc_pkg::PLANE_REGS];
  logic [NCELL-1:0] active;

  // Link k feeds cell k; link NCELL feeds the tail.
  cvc_pkg::ctrl_t       link_ctrl  [NCELL+1];
  logic [PAY_W-1:0]     link_pay   [NCELL+1];
  logic [3*PRW-1:0]     link_prod  [NCELL+1];
  logic signed [TW-1:0] link_thr   [NCELL+1];
  logic                 link_ready [NCELL+1];
  logic                 res_in_vol;

  cvc_cfg #(
    .COORD_BITS  (COORD_BITS),
    .NORMAL_BITS (NORMAL_BITS),
    .NCELL       (NCELL)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .plane_o   (plane),
    .active_o  (active)
  );

  // A fresh request starts inside, with no plane pending a compare.
  always_comb begin
    link_ctrl[0].valid  = in_tvalid;
    link_ctrl[0].in_vol = 1'b1;
    link_ctrl[0].chk    = 1'b0;
  end
  assign link_pay[0]  = {in_tdata[FIELDS_W-1:0], in_tuser};
  assign link_prod[0] = '0;
  assign link_thr[0]  = '0;
  assign in_tready    = link_ready[0];

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    cvc_cell #(
      .COORD_BITS  (COORD_BITS),
      .NORMAL_BITS (NORMAL_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .plane_i    (plane[k]),
      .active_i   (active[k]),
      .up_ctrl_i  (link_ctrl[k]),
      .up_pay_i   (link_pay[k]),
      .up_prod_i  (link_prod[k]),
      .up_thr_i   (link_thr[k]),
      .up_ready_o (link_ready[k]),
      .dn_ctrl_o  (link_ctrl[k+1]),
      .dn_pay_o   (link_pay[k+1]),
      .dn_prod_o  (link_prod[k+1]),
      .dn_thr_o   (link_thr[k+1]),
      .dn_ready_i (link_ready[k+1])
    );
  end

  // The tail finishes the last plane; the payload is not needed there.
  cvc_tail #(
    .COORD_BITS  (COORD_BITS),
    .NORMAL_BITS (NORMAL_BITS)
  ) u_tail (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_ctrl_i    (link_ctrl[NCELL]),
    .up_prod_i    (link_prod[NCELL]),
    .up_thr_i     (link_thr[NCELL]),
    .up_ready_o   (link_ready[NCELL]),
    .out_valid_o  (out_tvalid),
    .out_inside_o (res_in_vol),
    .out_ready_i  (out_tready)
  );

  assign out_tdata = {7'b0, res_in_vol};

endmodule
